[design/mbd_pkg.sv]
// ----------------------------------------------------------------------------
// mbd_pkg: shared types and constants for the monocular ball distance block
// Holds register indexes, reset values, datapath widths, the CORDIC arctangent
// table and the structs passed between the front, queue and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

package mbd_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FOCAL_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FOCAL_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CENTER_ROW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BALL_DIAM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAM_HEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TILT        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CALIB_VALID = 3'd6;

    localparam logic [15:0] RST_FOCAL_X    = 16'd9600;
    localparam logic [15:0] RST_FOCAL_Y    = 16'd9600;
    localparam logic [15:0] RST_CENTER_ROW = 16'd3840;
    localparam logic [19:0] RST_BALL_DIAM  = 20'd65000;
    localparam logic [23:0] RST_CAM_HEIGHT = 24'd300000;

    // Datapath
    localparam int DIST_W           = 33;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TAB_LEN          = 24;
    localparam int TAB_W            = 23;
    localparam int XW               = 34;   // CORDIC x/y width
    localparam int ZW               = 28;   // CORDIC angle width, 2^-16 degree
    localparam int MIN_COUNT        = 3;
    localparam int QUEUE_DEPTH      = 4;
    localparam int DIV_NUM_W        = 55;   // 24-bit height times 31-bit cosine
    localparam int SZ_DEN_W         = 16;
    localparam int GD_DEN_W         = 31;

    localparam logic signed [ZW-1:0] DEG90 = ZW'(90 * 65536);

    localparam logic [TAB_W-1:0] ATAN_TAB [0:TAB_LEN-1] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
        23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
        23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29, 23'd14, 23'd7,
        23'd4, 23'd2, 23'd1, 23'd0
    };

    // Ground result selection
    localparam logic [1:0] GM_NONE = 2'd0;
    localparam logic [1:0] GM_ZERO = 2'd1;
    localparam logic [1:0] GM_MAX  = 2'd2;
    localparam logic [1:0] GM_DIV  = 2'd3;

    typedef struct packed {
        logic [15:0]        focal_x;
        logic [15:0]        focal_y;
        logic [15:0]        center_row;
        logic [19:0]        ball_diam;
        logic [23:0]        mount_height;
        logic signed [15:0] tilt;
        logic               calib;
    } t_cfg;

    typedef struct packed {
        logic               width_zero;
        logic [15:0]        width;
        logic signed [16:0] dy;
    } t_qent;

    typedef struct packed {
        logic        width_zero;
        logic        fy_zero;
        logic [15:0] width;
        logic [35:0] size_num;
        logic        ang_pos;
        logic        ang_ge90;
    } t_side;

    typedef struct packed {
        logic       width_zero;
        logic [1:0] mode;
    } t_dside;

    function automatic logic signed [ZW-1:0] tab_z(input int idx);
        tab_z = signed'({{(ZW-TAB_W){1'b0}}, ATAN_TAB[idx]});
    endfunction

endpackage

`default_nettype wire

[design/mbd_in_if.sv]
// ----------------------------------------------------------------------------
// mbd_in_if: detection channel
// Valid/ready channel carrying one ball detection per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbd_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  value_count;
    logic [15:0] pixel_row;
    logic [15:0] pixel_width;

    modport source (output valid, output value_count, output pixel_row,
                    output pixel_width, input ready);
    modport sink   (input valid, input value_count, input pixel_row,
                    input pixel_width, output ready);
endinterface

`default_nettype wire

[design/mbd_out_if.sv]
// ----------------------------------------------------------------------------
// mbd_out_if: distance channel
// Valid/ready channel carrying both distance estimates per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbd_out_if;
    logic               valid;
    logic               ready;
    logic signed [32:0] size_distance;
    logic signed [32:0] ground_distance;

    modport source (output valid, output size_distance, output ground_distance,
                    input ready);
    modport sink   (input valid, input size_distance, input ground_distance,
                    output ready);
endinterface

`default_nettype wire

[design/monocular_ball_distance_top.sv]
// ----------------------------------------------------------------------------
// monocular_ball_distance_top: pinhole camera ball distance estimator
// Size-based and ground-plane distance of a detected ball, in micrometres.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake      payload
//   i_det     in   valid/ready    value_count, pixel_row, pixel_width
//   o_dist    out  valid/ready    size_distance, ground_distance
//   i_cfg_*   in   write enable   i_cfg_index, i_cfg_data
//
// One detection per cycle is taken and one result per cycle is given out
// while o_dist is ready. The path runs through the queue, two CORDIC chains
// of CORDIC_STEPS stages each and two 55-stage restoring dividers.
// A stall on o_dist freezes the whole arithmetic pipe; the front keeps taking
// beats until its 4-entry queue fills, then drops i_det.ready.
// Reset (i_rst_n low, synchronous) empties the queue and pipe and loads the
// register reset values; calibration starts out not valid.
// ----------------------------------------------------------------------------
`default_nettype none

module monocular_ball_distance_top #(
    parameter int CORDIC_STEPS = mbd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mbd_in_if.sink                          i_det,
    mbd_out_if.source                       o_dist,
    input  logic                            i_cfg_we,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    mbd_pkg::t_cfg  r_cfg;
    mbd_pkg::t_qent push_ent, q_ent;
    logic           push, q_full, q_valid, pop;

    // Configuration registers; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x      <= mbd_pkg::RST_FOCAL_X;
            r_cfg.focal_y      <= mbd_pkg::RST_FOCAL_Y;
            r_cfg.center_row   <= mbd_pkg::RST_CENTER_ROW;
            r_cfg.ball_diam    <= mbd_pkg::RST_BALL_DIAM;
            r_cfg.mount_height <= mbd_pkg::RST_CAM_HEIGHT;
            r_cfg.tilt         <= '0;
            r_cfg.calib        <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mbd_pkg::CFG_IDX_FOCAL_X:     r_cfg.focal_x      <= i_cfg_data[15:0];
                mbd_pkg::CFG_IDX_FOCAL_Y:     r_cfg.focal_y      <= i_cfg_data[15:0];
                mbd_pkg::CFG_IDX_CENTER_ROW:  r_cfg.center_row   <= i_cfg_data[15:0];
                mbd_pkg::CFG_IDX_BALL_DIAM:   r_cfg.ball_diam    <= i_cfg_data[19:0];
                mbd_pkg::CFG_IDX_CAM_HEIGHT:  r_cfg.mount_height <= i_cfg_data[23:0];
                mbd_pkg::CFG_IDX_TILT:        r_cfg.tilt         <= signed'(i_cfg_data[15:0]);
                mbd_pkg::CFG_IDX_CALIB_VALID: r_cfg.calib        <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Front: take beats, drop those that give no result.
    mbd_front u_front (
        .i_cfg  (r_cfg),
        .i_det  (i_det),
        .i_full (q_full),
        .o_push (push),
        .o_ent  (push_ent)
    );

    // Queue: hold accepted detections while the back end stalls.
    mbd_queue #(.DEPTH(mbd_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (push_ent),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_ent   (q_ent)
    );

    // Back: angles, products, divisions, saturation and output register.
    mbd_back #(.STEPS(CORDIC_STEPS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_ent   (q_ent),
        .o_pop     (pop),
        .o_dist    (o_dist)
    );
endmodule

`default_nettype wire

[design/mbd_front.sv]
// ----------------------------------------------------------------------------
// mbd_front: detection intake
// Accepts detections, drops those that yield no result and forms queue entries.
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_front (
    input  mbd_pkg::t_cfg  i_cfg,
    mbd_in_if.sink         i_det,
    input  logic           i_full,
    output logic           o_push,
    output mbd_pkg::t_qent o_ent
);
    logic keep;

    assign i_det.ready = !i_full;
    // drop when uncalibrated or too few values
    assign keep   = i_cfg.calib && (i_det.value_count >= 4'(mbd_pkg::MIN_COUNT));
    assign o_push = i_det.valid && !i_full && keep;

    assign o_ent.width_zero = (i_det.pixel_width == 16'd0);
    assign o_ent.width      = i_det.pixel_width;
    assign o_ent.dy         = signed'({1'b0, i_det.pixel_row})
                            - signed'({1'b0, i_cfg.center_row});
endmodule

`default_nettype wire

[design/mbd_queue.sv]
// ----------------------------------------------------------------------------
// mbd_queue: front-to-back queue
// Small FIFO that decouples detection intake from the arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_queue #(
    parameter int DEPTH = mbd_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mbd_pkg::t_qent i_ent,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output mbd_pkg::t_qent o_ent
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    mbd_pkg::t_qent r_mem [0:DEPTH-1];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_ent   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

`default_nettype wire

[design/mbd_div.sv]
// ----------------------------------------------------------------------------
// mbd_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage, NUM_W stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_div #(
    parameter int NUM_W = mbd_pkg::DIV_NUM_W,
    parameter int DEN_W = mbd_pkg::GD_DEN_W
) (
    input  logic             i_clk,
    input  logic             i_adv,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);
    logic [NUM_W-1:0] r_num [1:NUM_W];
    logic [DEN_W-1:0] r_den [1:NUM_W];
    logic [DEN_W-1:0] r_rem [1:NUM_W];
    logic [NUM_W-1:0] r_quo [1:NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [NUM_W-1:0] cur_num;
        logic [DEN_W-1:0] cur_den;
        logic [DEN_W-1:0] cur_rem;
        logic [NUM_W-1:0] cur_quo;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign cur_num = i_num;
            assign cur_den = i_den;
            assign cur_rem = '0;
            assign cur_quo = '0;
        end else begin : g_next
            assign cur_num = r_num[k];
            assign cur_den = r_den[k];
            assign cur_rem = r_rem[k];
            assign cur_quo = r_quo[k];
        end

        // bring down the next numerator bit, subtract when it fits
        assign trial = {cur_rem, cur_num[NUM_W-1-k]};
        assign diff  = trial - {1'b0, cur_den};
        assign ge    = (trial >= {1'b0, cur_den});

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_num[k+1] <= cur_num;
                r_den[k+1] <= cur_den;
                r_rem[k+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_quo[k+1] <= {cur_quo[NUM_W-2:0], ge};
            end
        end
    end

    assign o_quo = r_quo[NUM_W];
endmodule

`default_nettype wire

[design/mbd_back.sv]
// ----------------------------------------------------------------------------
// mbd_back: distance pipeline
// CORDIC arctangent, tilt add, CORDIC rotation, products, two dividers and
// the output register. The whole pipe moves as one when the output can take.
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_back #(
    parameter int STEPS = mbd_pkg::CORDIC_STEPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mbd_pkg::t_cfg  i_cfg,
    input  logic           i_q_valid,
    input  mbd_pkg::t_qent i_q_ent,
    output logic           o_pop,
    mbd_out_if.source      o_dist
);
    localparam int XW = mbd_pkg::XW;
    localparam int ZW = mbd_pkg::ZW;
    localparam int NW = mbd_pkg::DIV_NUM_W;

    logic adv;

    // arctangent (vectoring) stages
    logic                 r_av [0:STEPS];
    mbd_pkg::t_side       r_as [0:STEPS];
    logic signed [XW-1:0] r_ax [0:STEPS];
    logic signed [XW-1:0] r_ay [0:STEPS];
    logic signed [ZW-1:0] r_az [0:STEPS];

    // rotation stages
    logic                 r_rv [0:STEPS];
    mbd_pkg::t_side       r_rs [0:STEPS];
    logic signed [XW-1:0] r_rx [0:STEPS];
    logic signed [XW-1:0] r_ry [0:STEPS];
    logic signed [ZW-1:0] r_rz [0:STEPS];

    // product stage and divider alignment
    logic                      r_dv [0:NW];
    mbd_pkg::t_dside           r_ds [0:NW];
    logic [NW-1:0]             r_gnum;
    logic [mbd_pkg::GD_DEN_W-1:0] r_gden;
    logic [NW-1:0]             r_snum;
    logic [mbd_pkg::SZ_DEN_W-1:0] r_sden;
    logic [NW-1:0]             gquo, squo;

    logic                      r_out_valid;
    logic signed [32:0]        r_size, r_ground;

    mbd_pkg::t_side       side0;
    mbd_pkg::t_side       side_r;
    logic signed [ZW-1:0] ang;
    logic signed [XW-1:0] c_term, s_term;
    logic [1:0]           gmode;
    mbd_pkg::t_dside      dside;

    assign adv   = !r_out_valid || o_dist.ready;
    assign o_pop = adv;

    // ---- entry stage: load vectoring seed and size product
    always_comb begin
        side0.width_zero = i_q_ent.width_zero;
        side0.fy_zero    = (i_cfg.focal_y == 16'd0);
        side0.width      = i_q_ent.width;
        side0.size_num   = 36'(i_cfg.focal_x) * 36'(i_cfg.ball_diam);
        side0.ang_pos    = 1'b0;
        side0.ang_ge90   = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_as[0] <= side0;
            r_ax[0] <= signed'({{(XW-30){1'b0}}, i_cfg.focal_y, 14'd0});
            r_ay[0] <= signed'({{(XW-31){i_q_ent.dy[16]}}, i_q_ent.dy, 14'd0});
            r_az[0] <= '0;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_atan
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_as[i+1] <= r_as[i];
                if (!r_ay[i][XW-1]) begin
                    r_ax[i+1] <= r_ax[i] + (r_ay[i] >>> i);
                    r_ay[i+1] <= r_ay[i] - (r_ax[i] >>> i);
                    r_az[i+1] <= r_az[i] + mbd_pkg::tab_z(i);
                end else begin
                    r_ax[i+1] <= r_ax[i] - (r_ay[i] >>> i);
                    r_ay[i+1] <= r_ay[i] + (r_ax[i] >>> i);
                    r_az[i+1] <= r_az[i] - mbd_pkg::tab_z(i);
                end
            end
        end
    end

    // ---- total angle: tilt scaled to 2^-16 degree plus line-of-sight angle
    assign ang = signed'({{(ZW-24){i_cfg.tilt[15]}}, i_cfg.tilt, 8'd0}) + r_az[STEPS];

    always_comb begin
        side_r          = r_as[STEPS];
        side_r.ang_pos  = !ang[ZW-1] && (ang != '0);
        side_r.ang_ge90 = (ang >= mbd_pkg::DEG90);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rs[0] <= side_r;
            r_rx[0] <= signed'(XW'(64'd1 << 30));
            r_ry[0] <= '0;
            r_rz[0] <= ang;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_rs[i+1] <= r_rs[i];
                if (!r_rz[i][ZW-1]) begin
                    r_rx[i+1] <= r_rx[i] - (r_ry[i] >>> i);
                    r_ry[i+1] <= r_ry[i] + (r_rx[i] >>> i);
                    r_rz[i+1] <= r_rz[i] - mbd_pkg::tab_z(i);
                end else begin
                    r_rx[i+1] <= r_rx[i] + (r_ry[i] >>> i);
                    r_ry[i+1] <= r_ry[i] - (r_rx[i] >>> i);
                    r_rz[i+1] <= r_rz[i] + mbd_pkg::tab_z(i);
                end
            end
        end
    end

    // ---- classify the ground result, form dividends
    assign c_term = r_rx[STEPS];
    assign s_term = r_ry[STEPS];

    always_comb begin
        if (r_rs[STEPS].width_zero || r_rs[STEPS].fy_zero || !r_rs[STEPS].ang_pos) begin
            gmode = mbd_pkg::GM_NONE;
        end else if (r_rs[STEPS].ang_ge90 || c_term[XW-1] || (c_term == '0)) begin
            gmode = mbd_pkg::GM_ZERO;
        end else if (s_term[XW-1] || (s_term == '0)) begin
            gmode = mbd_pkg::GM_MAX;
        end else begin
            gmode = mbd_pkg::GM_DIV;
        end
        dside.width_zero = r_rs[STEPS].width_zero;
        dside.mode       = gmode;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ds[0] <= dside;
            r_gnum  <= NW'(i_cfg.mount_height) * NW'(c_term[mbd_pkg::GD_DEN_W-1:0]);
            r_gden  <= s_term[mbd_pkg::GD_DEN_W-1:0];
            r_snum  <= NW'(r_rs[STEPS].size_num);
            r_sden  <= r_rs[STEPS].width;
        end
    end

    mbd_div #(.NUM_W(NW), .DEN_W(mbd_pkg::GD_DEN_W)) u_gdiv (
        .i_clk (i_clk),
        .i_adv (adv),
        .i_num (r_gnum),
        .i_den (r_gden),
        .o_quo (gquo)
    );

    mbd_div #(.NUM_W(NW), .DEN_W(mbd_pkg::SZ_DEN_W)) u_sdiv (
        .i_clk (i_clk),
        .i_adv (adv),
        .i_num (r_snum),
        .i_den (r_sden),
        .o_quo (squo)
    );

    for (genvar k = 0; k < NW; k++) begin : g_align
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_ds[k+1] <= r_ds[k];
            end
        end
    end

    // ---- valid bits of every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= STEPS; k++) begin
                r_av[k] <= 1'b0;
                r_rv[k] <= 1'b0;
            end
            for (int k = 0; k <= NW; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (adv) begin
            r_av[0] <= i_q_valid;
            for (int k = 0; k < STEPS; k++) begin
                r_av[k+1] <= r_av[k];
                r_rv[k+1] <= r_rv[k];
            end
            r_rv[0] <= r_av[STEPS];
            r_dv[0] <= r_rv[STEPS];
            for (int k = 0; k < NW; k++) begin
                r_dv[k+1] <= r_dv[k];
            end
        end
    end

    // ---- output register with saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_dv[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_ds[NW].width_zero) begin
                r_size <= '1;
            end else if (|squo[NW-1:32]) begin
                r_size <= {1'b0, 32'hFFFF_FFFF};
            end else begin
                r_size <= {1'b0, squo[31:0]};
            end
            case (r_ds[NW].mode)
                mbd_pkg::GM_NONE: r_ground <= '1;
                mbd_pkg::GM_ZERO: r_ground <= '0;
                mbd_pkg::GM_MAX:  r_ground <= {1'b0, 32'hFFFF_FFFF};
                mbd_pkg::GM_DIV: begin
                    if (|gquo[NW-1:32]) begin
                        r_ground <= {1'b0, 32'hFFFF_FFFF};
                    end else begin
                        r_ground <= {1'b0, gquo[31:0]};
                    end
                end
                default: r_ground <= '1;
            endcase
        end
    end

    assign o_dist.valid           = r_out_valid;
    assign o_dist.size_distance   = r_size;
    assign o_dist.ground_distance = r_ground;
endmodule

`default_nettype wire
